// File: hdl/oale_pkg.sv
package oale_pkg;

  // Field widths of one item.
  localparam int NUM_W = 32;
  localparam int SCORE_W = 24;
  // Position and count width, enough for the largest list.
  localparam int POS_W = 11;
  localparam int DEFAULT_CAPACITY = 64;

  typedef enum logic [3:0] {
    K_ADD_TAIL   = 4'd0,
    K_PUSH_FRONT = 4'd1,
    K_POP_BACK   = 4'd2,
    K_TAKE_HEAD  = 4'd3,
    K_INSERT_AT  = 4'd4,
    K_DELETE_AT  = 4'd5,
    K_FIND       = 4'd6,
    K_DEL_SCORE  = 4'd7,
    K_SORT       = 4'd8,
    K_REVERSE    = 4'd9,
    K_CLEAR      = 4'd10,
    K_READ_AT    = 4'd11
  } kind_t;

  typedef enum logic [2:0] {
    S_OK       = 3'd0,
    S_FULL     = 3'd1,
    S_EMPTY    = 3'd2,
    S_BADPOS   = 3'd3,
    S_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SORT,
    ST_REV,
    ST_ROT,
    ST_FIN
  } state_t;

  // What every cell does on a clock edge.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_ROT,
    OP_INS,
    OP_DEL,
    OP_SORT,
    OP_REV
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic [POS_W-1:0]          pos;
    logic [POS_W-1:0]          cnt;
    logic                      parity;
    logic signed [NUM_W-1:0]   new_num;
    logic signed [SCORE_W-1:0] new_score;
  } cell_cmd_t;

endpackage

// File: hdl/oale_cell.sv
module oale_cell #(
  parameter int IDX = 0,
  parameter int CAPACITY = oale_pkg::DEFAULT_CAPACITY
) (
  input  logic                               clk,
  input  oale_pkg::cell_cmd_t                cmd,
  input  logic signed [oale_pkg::NUM_W-1:0]   left_num,
  input  logic signed [oale_pkg::SCORE_W-1:0] left_score,
  input  logic signed [oale_pkg::NUM_W-1:0]   right_num,
  input  logic signed [oale_pkg::SCORE_W-1:0] right_score,
  input  logic signed [oale_pkg::NUM_W-1:0]   mirror_num,
  input  logic signed [oale_pkg::SCORE_W-1:0] mirror_score,
  output logic signed [oale_pkg::NUM_W-1:0]   num,
  output logic signed [oale_pkg::SCORE_W-1:0] score
);

  localparam logic [oale_pkg::POS_W-1:0] MY_IDX = oale_pkg::POS_W'(IDX);
  localparam logic [oale_pkg::POS_W-1:0] NEXT_IDX = oale_pkg::POS_W'(IDX + 1);
  localparam bit IS_FIRST = (IDX == 0);
  localparam bit IS_LAST = (IDX == CAPACITY - 1);
  localparam logic MY_PAR = 1'(IDX % 2);

  logic signed [oale_pkg::NUM_W-1:0]   num_r, num_nxt;
  logic signed [oale_pkg::SCORE_W-1:0] score_r, score_nxt;
  logic pair_left;

  // Select the next record from this cell or a neighbor.
  always_comb begin
    num_nxt = num_r;
    score_nxt = score_r;
    pair_left = (MY_PAR == cmd.parity);
    unique case (cmd.op)
      oale_pkg::OP_HOLD: ;
      oale_pkg::OP_ROT: begin
        num_nxt = right_num;
        score_nxt = right_score;
      end
      oale_pkg::OP_INS: begin
        if (!IS_FIRST && MY_IDX > cmd.pos) begin
          num_nxt = left_num;
          score_nxt = left_score;
        end else if (MY_IDX == cmd.pos) begin
          num_nxt = cmd.new_num;
          score_nxt = cmd.new_score;
        end
      end
      oale_pkg::OP_DEL: begin
        if (!IS_LAST && MY_IDX >= cmd.pos) begin
          num_nxt = right_num;
          score_nxt = right_score;
        end
      end
      oale_pkg::OP_SORT: begin
        // Compare-exchange with the partner cell; strict order keeps it stable.
        if (pair_left) begin
          if (!IS_LAST && NEXT_IDX < cmd.cnt && score_r < right_score) begin
            num_nxt = right_num;
            score_nxt = right_score;
          end
        end else if (!IS_FIRST && MY_IDX < cmd.cnt && left_score < score_r) begin
          num_nxt = left_num;
          score_nxt = left_score;
        end
      end
      oale_pkg::OP_REV: begin
        num_nxt = mirror_num;
        score_nxt = mirror_score;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    score_r <= score_nxt;
  end

  assign num = num_r;
  assign score = score_r;

endmodule

// File: hdl/ordered_array_list_engine.sv
// Push, insert, clear, unknown kinds and any request refused at accept go straight to the
// finishing step; pop, delete, find and read first rotate the cell ring once in full; sort
// runs odd-even rounds over the ring; reverse mirrors it, then rotates the live records back.
// Throughput: one item at a time; busy stays high until the result is issued.
// Reset clears the count and control state; cell contents are undefined until written.
// Results are issued as a one-cycle strobe; the receiver cannot stall.
module ordered_array_list_engine #(
  parameter int CAPACITY = oale_pkg::DEFAULT_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [3:0]                          in_kind,
  input  logic signed [oale_pkg::NUM_W-1:0]   in_entry_number,
  input  logic signed [oale_pkg::SCORE_W-1:0] in_entry_score,
  input  logic [6:0]                          in_position,
  output logic                                out_valid,
  output logic [2:0]                          out_status,
  output logic signed [oale_pkg::NUM_W-1:0]   out_record_number,
  output logic signed [oale_pkg::SCORE_W-1:0] out_record_score,
  output logic [5:0]                          out_record_index,
  output logic [6:0]                          out_entry_count
);

  localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = oale_pkg::POS_W;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
  localparam logic [IW-1:0] LAST_T = IW'(CAPACITY - 1);

  oale_pkg::state_t state_r, state_nxt;
  oale_pkg::kind_t kind_r, kind_nxt, in_kind_e;
  oale_pkg::status_t stat_r, stat_nxt;
  logic signed [oale_pkg::NUM_W-1:0]   num_r, num_nxt;
  logic signed [oale_pkg::SCORE_W-1:0] key_r, key_nxt;
  logic [PW-1:0] tgt_r, tgt_nxt;
  logic [PW-1:0] rc_r, rc_nxt;
  logic [IW-1:0] t_r, t_nxt;
  logic [IW-1:0] hit_r, hit_nxt;
  logic found_r, found_nxt;
  logic signed [oale_pkg::NUM_W-1:0]   rec_num_r, rec_num_nxt;
  logic signed [oale_pkg::SCORE_W-1:0] rec_score_r, rec_score_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [2:0] out_status_r, out_status_nxt;
  logic signed [oale_pkg::NUM_W-1:0]   out_num_r, out_num_nxt;
  logic signed [oale_pkg::SCORE_W-1:0] out_score_r, out_score_nxt;
  logic [5:0] out_index_r, out_index_nxt;
  logic [6:0] out_count_r, out_count_nxt;

  oale_pkg::cell_cmd_t cmd;
  logic [PW-1:0] cnt_x, pos_x, t_x, in_tgt;
  logic accept;

  logic signed [oale_pkg::NUM_W-1:0]   cell_num [CAPACITY];
  logic signed [oale_pkg::SCORE_W-1:0] cell_score [CAPACITY];

  // Ring of record cells.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    localparam int LI = (gi == 0) ? 0 : gi - 1;
    localparam int RI = (gi + 1) % CAPACITY;
    localparam int MI = CAPACITY - 1 - gi;
    oale_cell #(.IDX(gi), .CAPACITY(CAPACITY)) u_cell (
      .clk(clk),
      .cmd(cmd),
      .left_num(cell_num[LI]),
      .left_score(cell_score[LI]),
      .right_num(cell_num[RI]),
      .right_score(cell_score[RI]),
      .mirror_num(cell_num[MI]),
      .mirror_score(cell_score[MI]),
      .num(cell_num[gi]),
      .score(cell_score[gi])
    );
  end

  assign accept = start && (state_r == oale_pkg::ST_IDLE);
  assign busy = (state_r != oale_pkg::ST_IDLE);
  assign cnt_x = PW'(count_r);
  assign pos_x = PW'(in_position);
  assign t_x = PW'(t_r);
  assign in_kind_e = oale_pkg::kind_t'(in_kind);

  // Next state, cell command and result.
  always_comb begin
    state_nxt = state_r;
    kind_nxt = kind_r;
    stat_nxt = stat_r;
    num_nxt = num_r;
    key_nxt = key_r;
    tgt_nxt = tgt_r;
    rc_nxt = rc_r;
    t_nxt = t_r;
    hit_nxt = hit_r;
    found_nxt = found_r;
    rec_num_nxt = rec_num_r;
    rec_score_nxt = rec_score_r;
    count_nxt = count_r;
    out_valid_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_num_nxt = out_num_r;
    out_score_nxt = out_score_r;
    out_index_nxt = out_index_r;
    out_count_nxt = out_count_r;
    in_tgt = pos_x;
    cmd.op = oale_pkg::OP_HOLD;
    cmd.pos = tgt_r;
    cmd.cnt = cnt_x;
    cmd.parity = t_r[0];
    cmd.new_num = num_r;
    cmd.new_score = key_r;

    unique case (state_r)
      oale_pkg::ST_IDLE: begin
        if (accept) begin
          kind_nxt = in_kind_e;
          num_nxt = in_entry_number;
          key_nxt = in_entry_score;
          stat_nxt = oale_pkg::S_OK;
          found_nxt = 1'b0;
          t_nxt = '0;
          state_nxt = oale_pkg::ST_FIN;
          unique case (in_kind_e)
            oale_pkg::K_ADD_TAIL, oale_pkg::K_PUSH_FRONT, oale_pkg::K_INSERT_AT: begin
              if (in_kind_e == oale_pkg::K_ADD_TAIL) in_tgt = cnt_x;
              else if (in_kind_e == oale_pkg::K_PUSH_FRONT) in_tgt = '0;
              if (cnt_x >= CAP_P) stat_nxt = oale_pkg::S_FULL;
              else if (in_tgt > cnt_x) stat_nxt = oale_pkg::S_BADPOS;
            end
            oale_pkg::K_POP_BACK, oale_pkg::K_TAKE_HEAD, oale_pkg::K_DELETE_AT: begin
              if (in_kind_e == oale_pkg::K_POP_BACK) in_tgt = cnt_x - 1'b1;
              else if (in_kind_e == oale_pkg::K_TAKE_HEAD) in_tgt = '0;
              if (count_r == '0) stat_nxt = oale_pkg::S_EMPTY;
              else if (in_tgt >= cnt_x) stat_nxt = oale_pkg::S_BADPOS;
              else state_nxt = oale_pkg::ST_SCAN;
            end
            oale_pkg::K_READ_AT: begin
              if (in_tgt >= cnt_x) stat_nxt = oale_pkg::S_BADPOS;
              else state_nxt = oale_pkg::ST_SCAN;
            end
            oale_pkg::K_FIND, oale_pkg::K_DEL_SCORE: state_nxt = oale_pkg::ST_SCAN;
            oale_pkg::K_SORT: state_nxt = oale_pkg::ST_SORT;
            oale_pkg::K_REVERSE: begin
              rc_nxt = CAP_P - cnt_x;
              state_nxt = oale_pkg::ST_REV;
            end
            default: ;
          endcase
          tgt_nxt = in_tgt;
        end
      end
      oale_pkg::ST_SCAN: begin
        // Cell 0 holds the record at index t; rotate it past once.
        cmd.op = oale_pkg::OP_ROT;
        if (kind_r == oale_pkg::K_FIND || kind_r == oale_pkg::K_DEL_SCORE) begin
          if (!found_r && t_x < cnt_x && cell_score[0] == key_r) begin
            found_nxt = 1'b1;
            hit_nxt = t_r;
            rec_num_nxt = cell_num[0];
            rec_score_nxt = cell_score[0];
          end
        end else if (t_x == tgt_r) begin
          found_nxt = 1'b1;
          hit_nxt = t_r;
          rec_num_nxt = cell_num[0];
          rec_score_nxt = cell_score[0];
        end
        t_nxt = t_r + 1'b1;
        if (t_r == LAST_T) begin
          t_nxt = '0;
          state_nxt = oale_pkg::ST_FIN;
        end
      end
      oale_pkg::ST_SORT: begin
        cmd.op = oale_pkg::OP_SORT;
        t_nxt = t_r + 1'b1;
        if (t_r == LAST_T) begin
          t_nxt = '0;
          state_nxt = oale_pkg::ST_FIN;
        end
      end
      oale_pkg::ST_REV: begin
        // Mirror the whole ring, then rotate the live prefix back to the front.
        cmd.op = oale_pkg::OP_REV;
        state_nxt = (rc_r == '0) ? oale_pkg::ST_FIN : oale_pkg::ST_ROT;
      end
      oale_pkg::ST_ROT: begin
        cmd.op = oale_pkg::OP_ROT;
        rc_nxt = rc_r - 1'b1;
        if (rc_r == PW'(1)) state_nxt = oale_pkg::ST_FIN;
      end
      oale_pkg::ST_FIN: begin
        state_nxt = oale_pkg::ST_IDLE;
        out_valid_nxt = 1'b1;
        out_status_nxt = stat_r;
        out_num_nxt = '0;
        out_score_nxt = '0;
        out_index_nxt = '0;
        if (stat_r == oale_pkg::S_OK) begin
          unique case (kind_r)
            oale_pkg::K_ADD_TAIL, oale_pkg::K_PUSH_FRONT, oale_pkg::K_INSERT_AT: begin
              cmd.op = oale_pkg::OP_INS;
              count_nxt = count_r + 1'b1;
              out_num_nxt = num_r;
              out_score_nxt = key_r;
              out_index_nxt = 6'(tgt_r);
            end
            oale_pkg::K_POP_BACK, oale_pkg::K_TAKE_HEAD, oale_pkg::K_DELETE_AT,
            oale_pkg::K_FIND, oale_pkg::K_DEL_SCORE, oale_pkg::K_READ_AT: begin
              if (found_r) begin
                out_num_nxt = rec_num_r;
                out_score_nxt = rec_score_r;
                out_index_nxt = 6'(hit_r);
                if (kind_r != oale_pkg::K_FIND && kind_r != oale_pkg::K_READ_AT) begin
                  cmd.op = oale_pkg::OP_DEL;
                  cmd.pos = PW'(hit_r);
                  count_nxt = count_r - 1'b1;
                end
              end else begin
                out_status_nxt = oale_pkg::S_NOTFOUND;
              end
            end
            oale_pkg::K_CLEAR: count_nxt = '0;
            default: ;
          endcase
        end
        out_count_nxt = 7'(count_nxt);
      end
      default: state_nxt = oale_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= oale_pkg::ST_IDLE;
      count_r <= '0;
      out_valid_r <= 1'b0;
      t_r <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
      t_r <= t_nxt;
      found_r <= found_nxt;
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    stat_r <= stat_nxt;
    num_r <= num_nxt;
    key_r <= key_nxt;
    tgt_r <= tgt_nxt;
    rc_r <= rc_nxt;
    hit_r <= hit_nxt;
    rec_num_r <= rec_num_nxt;
    rec_score_r <= rec_score_nxt;
    out_status_r <= out_status_nxt;
    out_num_r <= out_num_nxt;
    out_score_r <= out_score_nxt;
    out_index_r <= out_index_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_record_number = out_num_r;
  assign out_record_score = out_score_r;
  assign out_record_index = out_index_r;
  assign out_entry_count = out_count_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    PW'(count_r) <= CAP_P)
    else $error("count exceeds capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not make the block busy");

  a_result_follows_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == oale_pkg::ST_FIN)
    else $error("result strobe without finishing step");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CAP = 64;
  localparam int IDLE_LIMIT = 2000;

  // One answer of the list engine.
  typedef struct {
    logic [2:0]  status;
    logic [31:0] number;
    logic [23:0] score;
    logic [5:0]  index;
    logic [6:0]  count;
  } answer_t;

  // Scoreboard: keeps a shadow copy of the list and the answers still owed.
  class list_scoreboard;
    logic [31:0] numbers[CAP];
    logic [23:0] scores[CAP];
    int          held;
    answer_t     owed[$];
    int          errors;

    function new();
      held = 0;
      errors = 0;
    endfunction

    function void fill(ref answer_t a, input int idx);
      a.number = numbers[idx];
      a.score = scores[idx];
      a.index = idx[5:0];
    endfunction

    function void remove(int at);
      for (int i = at; i + 1 < held; i++) begin
        numbers[i] = numbers[i + 1];
        scores[i] = scores[i + 1];
      end
      held--;
    endfunction

    // Applies one accepted request to the shadow list and queues its answer.
    function void note_request(logic [3:0] kind, logic [31:0] num, logic [23:0] sc,
                               logic [6:0] position);
      answer_t a;
      int p, hit, j;
      logic [31:0] tn;
      logic [23:0] ts;
      a.status = oale_pkg::S_OK;
      a.number = '0;
      a.score = '0;
      a.index = '0;
      p = position;
      case (kind)
        oale_pkg::K_ADD_TAIL, oale_pkg::K_PUSH_FRONT, oale_pkg::K_INSERT_AT: begin
          if (kind == oale_pkg::K_ADD_TAIL) p = held;
          if (kind == oale_pkg::K_PUSH_FRONT) p = 0;
          if (held >= CAP) a.status = oale_pkg::S_FULL;
          else if (p > held) a.status = oale_pkg::S_BADPOS;
          else begin
            for (int i = held; i > p; i--) begin
              numbers[i] = numbers[i - 1];
              scores[i] = scores[i - 1];
            end
            numbers[p] = num;
            scores[p] = sc;
            held++;
            fill(a, p);
          end
        end
        oale_pkg::K_POP_BACK, oale_pkg::K_TAKE_HEAD, oale_pkg::K_DELETE_AT: begin
          if (kind == oale_pkg::K_POP_BACK) p = held - 1;
          if (kind == oale_pkg::K_TAKE_HEAD) p = 0;
          if (held == 0) a.status = oale_pkg::S_EMPTY;
          else if (p >= held) a.status = oale_pkg::S_BADPOS;
          else begin
            fill(a, p);
            remove(p);
          end
        end
        oale_pkg::K_FIND, oale_pkg::K_DEL_SCORE: begin
          hit = -1;
          for (int i = 0; i < held; i++)
            if (hit < 0 && scores[i] == sc) hit = i;
          if (hit < 0) a.status = oale_pkg::S_NOTFOUND;
          else begin
            fill(a, hit);
            if (kind == oale_pkg::K_DEL_SCORE) remove(hit);
          end
        end
        oale_pkg::K_SORT: begin
          // Stable insertion sort, highest score first.
          for (int i = 1; i < held; i++) begin
            tn = numbers[i];
            ts = scores[i];
            j = i;
            while (j > 0 && $signed(scores[j - 1]) < $signed(ts)) begin
              numbers[j] = numbers[j - 1];
              scores[j] = scores[j - 1];
              j--;
            end
            numbers[j] = tn;
            scores[j] = ts;
          end
        end
        oale_pkg::K_REVERSE: begin
          for (int i = 0; i < held / 2; i++) begin
            tn = numbers[i];
            numbers[i] = numbers[held - 1 - i];
            numbers[held - 1 - i] = tn;
            ts = scores[i];
            scores[i] = scores[held - 1 - i];
            scores[held - 1 - i] = ts;
          end
        end
        oale_pkg::K_CLEAR: held = 0;
        oale_pkg::K_READ_AT: begin
          if (p >= held) a.status = oale_pkg::S_BADPOS;
          else fill(a, p);
        end
        default: ;
      endcase
      a.count = held[6:0];
      owed.insert(owed.size(), a);
    endfunction

    // Compares one answer from the block with the oldest one owed.
    function void check_answer(answer_t got);
      answer_t w;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, got.status);
        errors++;
        return;
      end
      w = owed[0];
      owed.delete(0);
      if (got.status !== w.status) begin
        $display("%0t: status expected %0d actual %0d", $time, w.status, got.status);
        errors++;
      end
      if (got.number !== w.number) begin
        $display("%0t: number expected %h actual %h", $time, w.number, got.number);
        errors++;
      end
      if (got.score !== w.score) begin
        $display("%0t: score expected %h actual %h", $time, w.score, got.score);
        errors++;
      end
      if (got.index !== w.index) begin
        $display("%0t: index expected %0d actual %0d", $time, w.index, got.index);
        errors++;
      end
      if (got.count !== w.count) begin
        $display("%0t: count expected %0d actual %0d", $time, w.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  in_kind = '0;
  logic signed [31:0] in_entry_number = '0;
  logic signed [23:0] in_entry_score = '0;
  logic [6:0]  in_position = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic signed [31:0] out_record_number;
  logic signed [23:0] out_record_score;
  logic [5:0]  out_record_index;
  logic [6:0]  out_entry_count;

  list_scoreboard board = new();
  int idle_cycles = 0;
  logic [23:0] recent_scores[$];

  always #1 clk = ~clk;

  ordered_array_list_engine #(.CAPACITY(CAP)) dut (.*);

  // Note accepted requests and check results on each rising edge.
  always @(posedge clk) begin
    answer_t got;
    if (rst_n) begin
      if (start && !busy)
        board.note_request(in_kind, in_entry_number, in_entry_score, in_position);
      if (out_valid) begin
        got.status = out_status;
        got.number = out_record_number;
        got.score = out_record_score;
        got.index = out_record_index;
        got.count = out_entry_count;
        board.check_answer(got);
      end
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Sends one request and waits until it is accepted; start stays high for a
  // following item without a gap.
  task automatic send_item(logic [3:0] kind, logic [31:0] num, logic [23:0] sc,
                           logic [6:0] position, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_entry_number <= num;
    in_entry_score <= sc;
    in_position <= position;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stops sending and waits until every owed answer is in.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
  endtask

  // Random request, weighted toward useful kinds and scores seen before.
  task automatic random_item();
    logic [3:0]  kind;
    logic [23:0] sc;
    logic [6:0]  position;
    int r;
    r = $urandom_range(99);
    if (r < 35) kind = $urandom_range(1) ? oale_pkg::K_ADD_TAIL : oale_pkg::K_PUSH_FRONT;
    else if (r < 45) kind = oale_pkg::K_INSERT_AT;
    else if (r < 97) kind = 4'($urandom_range(oale_pkg::K_POP_BACK, oale_pkg::K_READ_AT));
    else kind = 4'($urandom_range(12, 15));
    if (kind == oale_pkg::K_CLEAR && $urandom_range(3) != 0) kind = oale_pkg::K_READ_AT;
    sc = 24'($urandom);
    if (recent_scores.size() != 0 && $urandom_range(1))
      sc = recent_scores[$urandom_range(recent_scores.size() - 1)];
    else if ($urandom_range(1)) sc = 24'(int'($urandom_range(7)) - 4);
    recent_scores.insert(recent_scores.size(), sc);
    if (recent_scores.size() > 16) recent_scores.delete(0);
    position = 7'($urandom_range(1) ? $urandom_range(board.held) : $urandom_range(127));
    send_item(kind, $urandom, sc, position, $urandom_range(5));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: errors on the empty list, extreme fields, every kind.
    send_item(oale_pkg::K_POP_BACK, 0, 0, 0, 0);
    send_item(oale_pkg::K_TAKE_HEAD, 0, 0, 0, 0);
    send_item(oale_pkg::K_DELETE_AT, 0, 0, 0, 0);
    send_item(oale_pkg::K_READ_AT, 0, 0, 0, 0);
    send_item(oale_pkg::K_FIND, 0, 0, 0, 0);
    send_item(oale_pkg::K_INSERT_AT, 1, 5, 1, 0);
    send_item(oale_pkg::K_ADD_TAIL, 32'h7fffffff, 24'h7fffff, 7'h7f, 0);
    send_item(oale_pkg::K_PUSH_FRONT, 32'h80000000, 24'h800000, 0, 1);
    send_item(oale_pkg::K_INSERT_AT, 32'hffffffff, 24'h7fffff, 1, 0);
    send_item(oale_pkg::K_INSERT_AT, 5, 24'hffffff, 3, 0);
    send_item(oale_pkg::K_SORT, 0, 0, 0, 2);
    send_item(oale_pkg::K_READ_AT, 0, 0, 1, 0);
    send_item(oale_pkg::K_REVERSE, 0, 0, 0, 0);
    send_item(oale_pkg::K_FIND, 0, 24'h7fffff, 0, 0);
    send_item(oale_pkg::K_DEL_SCORE, 0, 24'h800000, 0, 0);
    send_item(oale_pkg::K_DEL_SCORE, 0, 24'h123456, 0, 0);
    send_item(oale_pkg::K_DELETE_AT, 0, 0, 7'h7f, 0);
    send_item(oale_pkg::K_DELETE_AT, 0, 0, 1, 0);
    send_item(4'd15, 0, 0, 0, 0);
    send_item(oale_pkg::K_CLEAR, 0, 0, 0, 0);
    // Fill the list to show the full status.
    for (int i = 0; i < CAP; i++) send_item(oale_pkg::K_ADD_TAIL, 32'(i), 24'(i % 3), 0, 0);
    send_item(oale_pkg::K_PUSH_FRONT, 9, 9, 0, 0);
    send_item(oale_pkg::K_INSERT_AT, 9, 9, 0, 0);
    send_item(oale_pkg::K_SORT, 0, 0, 0, 0);
    send_item(oale_pkg::K_READ_AT, 0, 0, 63, 0);
    drain();
    send_item(oale_pkg::K_REVERSE, 0, 0, 0, 0);

    for (int n = 0; n < 1200; n++) begin
      random_item();
      // Hold off now and then until every answer is in.
      if (n % 300 == 150) drain();
    end

    drain();
    repeat (2 * CAP + 10) @(posedge clk);
    if (board.errors == 0 && board.owed.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
